FILE: src/fdt_pkg.sv
// Shared constants, types and helpers of the fingerprint duplicate table.
`default_nettype none

package fdt_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int POOL_ENTRIES = 4096;
    localparam int BUCKETS      = 1 << INDEX_BITS;
    localparam int ENTRY_BITS   = $clog2(POOL_ENTRIES);
    localparam int USED_BITS    = $clog2(POOL_ENTRIES + 1);
    localparam int NIBBLE_MASK  = 4'hF;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STAT_INSERTED = 2'd0,
        STAT_PRESENT  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_HEAD,
        ST_CHAIN,
        ST_DECIDE,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    // Bucket head or chain link: valid flag plus entry number
    typedef struct packed
    {
        logic                  valid;
        logic [ENTRY_BITS-1:0] ptr;
    } ref_t;

    // One pool entry: stored bytes 1..19 and the link to the next entry
    typedef struct packed
    {
        logic [23:0] key_top;
        logic [63:0] key_mid;
        logic [63:0] key_low;
        ref_t        link;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic    accept;
        logic    hold_head;
        logic    entry_rd;
        logic    entry_from_head;
        logic    sweep_wr;
        logic    do_insert;
        logic    load_out;
        status_t out_status;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed
    {
        logic in_valid;
        logic in_clear;
        logic head_valid;
        logic match;
        logic link_valid;
        logic full;
        logic sweep_last;
        logic out_free;
    } dp_sts_t;

    // Bucket: byte 0 shifted up, low nibble of byte 1 below it
    function automatic logic [INDEX_BITS-1:0] bucket_of(input logic [31:0] head);
        logic [31:0] idx;
        idx = 32'(head[31:24]) << (INDEX_BITS - 8);
        if (INDEX_BITS > 8)
        begin
            idx = idx | (32'(head[23:16]) & 32'(NIBBLE_MASK));
        end
        return idx[INDEX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/fdt_ctrl.sv
// Controller state machine of the fingerprint duplicate table.
`default_nettype none

module fdt_ctrl
    import fdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t result_reg;
    status_t result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            result_reg <= STAT_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = sts.in_clear ? ST_CLEAR : ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = sts.head_valid ? ST_CHAIN : ST_DECIDE;
            end
            ST_CHAIN:
            begin
                if (sts.match)
                begin
                    result_next = STAT_PRESENT;
                    state_next  = ST_RESULT;
                end
                else if (!sts.link_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                result_next = sts.full ? STAT_FULL : STAT_INSERTED;
                state_next  = ST_RESULT;
            end
            ST_CLEAR:
            begin
                if (sts.sweep_last)
                begin
                    result_next = STAT_CLEARED;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        cmd.out_status = result_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
            end
            ST_HEAD:
            begin
                cmd.hold_head       = 1'b1;
                cmd.entry_rd        = sts.head_valid;
                cmd.entry_from_head = 1'b1;
            end
            ST_CHAIN:
            begin
                cmd.entry_rd = !sts.match && sts.link_valid;
            end
            ST_DECIDE:
            begin
                cmd.do_insert = !sts.full;
            end
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/fdt_datapath.sv
// Datapath of the fingerprint duplicate table: request registers, tables, result register.
`default_nettype none

module fdt_datapath
    import fdt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic [159:0]  s_tdata,
    input  wire logic          s_tuser,
    output      logic          m_tvalid,
    input  wire logic          m_tready,
    output      logic [7:0]    m_tdata,
    input  wire ctl_cmd_t      cmd,
    output      dp_sts_t       sts
);

    logic [INDEX_BITS-1:0] idx_reg;
    logic [23:0]           key_top_reg;
    logic [63:0]           key_mid_reg;
    logic [63:0]           key_low_reg;
    ref_t                  head_reg;
    logic [USED_BITS-1:0]  used_reg;
    logic [INDEX_BITS-1:0] sweep_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;

    ref_t   bucket_mem [BUCKETS];
    entry_t entry_mem  [POOL_ENTRIES];
    ref_t   bucket_rdata;
    entry_t entry_rdata;

    logic [INDEX_BITS-1:0] rd_idx;
    logic [ENTRY_BITS-1:0] entry_rd_addr;
    entry_t                new_entry;

    assign rd_idx        = bucket_of(s_tdata[31:0]);
    assign entry_rd_addr = cmd.entry_from_head ? bucket_rdata.ptr : entry_rdata.link.ptr;

    always_comb
    begin
        new_entry.key_top = key_top_reg;
        new_entry.key_mid = key_mid_reg;
        new_entry.key_low = key_low_reg;
        new_entry.link    = head_reg;
    end

    // Request capture and head hold
    always_ff @(posedge clk)
    begin
        if (cmd.accept && s_tvalid)
        begin
            idx_reg     <= rd_idx;
            key_top_reg <= s_tdata[23:0];
            key_mid_reg <= s_tdata[95:32];
            key_low_reg <= s_tdata[159:96];
        end
        if (cmd.hold_head)
        begin
            head_reg <= bucket_rdata;
        end
    end

    // Bucket heads: read at acceptance, write on insert or sweep
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            bucket_mem[sweep_reg] <= '0;
        end
        else if (cmd.do_insert)
        begin
            bucket_mem[idx_reg] <= '{valid: 1'b1, ptr: used_reg[ENTRY_BITS-1:0]};
        end
        bucket_rdata <= bucket_mem[rd_idx];
    end

    // Pool entries
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            entry_mem[used_reg[ENTRY_BITS-1:0]] <= new_entry;
        end
        if (cmd.entry_rd)
        begin
            entry_rdata <= entry_mem[entry_rd_addr];
        end
    end

    // Control state: fill count, sweep counter, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_INSERTED;
        end
        else
        begin
            if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sts.sweep_last)
                begin
                    used_reg <= '0;
                end
            end
            else if (cmd.do_insert)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= cmd.out_status;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.in_valid   = s_tvalid;
        sts.in_clear   = (s_tuser == OP_CLEAR);
        sts.head_valid = bucket_rdata.valid;
        sts.match      = (entry_rdata.key_top == key_top_reg) &&
                         (entry_rdata.key_mid == key_mid_reg) &&
                         (entry_rdata.key_low == key_low_reg);
        sts.link_valid = entry_rdata.link.valid;
        sts.full       = (used_reg == USED_BITS'(POOL_ENTRIES));
        sts.sweep_last = (sweep_reg == {INDEX_BITS{1'b1}});
        sts.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg};

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while the result register is still occupied");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> !sts.full)
        else $error("insert issued with the pool exhausted");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_BITS'(POOL_ENTRIES))
        else $error("fill count beyond pool size");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> used_reg == $past(used_reg) + 1'b1)
        else $error("insert did not advance the fill count");

endmodule

`default_nettype wire

FILE: src/fingerprint_duplicate_table.sv
// Top level of the fingerprint duplicate table.
//
// Usage: each request on the slave stream is either an insert (s_tuser low)
// carrying a 160-bit fingerprint in s_tdata, or a clear (s_tuser high).
// Every request yields exactly one status byte on the master stream:
// inserted, already present, table full, or cleared.
// An insert reads its bucket head, then follows the chain one pool entry per
// cycle through the entry memory's single read port, comparing bytes 1..19.
// A hit ends the walk early; otherwise a decide step after the walk gives
// the inserted or table-full answer.
// A clear sweeps the bucket memory one bucket a cycle.
// One request is in flight at a time; the next is accepted in the cycle after
// the previous result is loaded, even while that result waits in the output
// register for m_tready. A stalled receiver holds the block only when a second
// result is ready before the first is taken.
// After reset the block runs the same sweep over the bucket memory before
// s_tready rises.
`default_nettype none

module fingerprint_duplicate_table
    import fdt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [159:0] s_tdata,   // fpr_head[31:0], fpr_mid[95:32], fpr_tail[159:96]
    input  wire logic         s_tuser,   // opcode
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [7:0]   m_tdata    // status[1:0], zero above
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // Sequencing of lookup, insert and sweep
    fdt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Tables, request registers and the output holding register
    fdt_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Accept only while the controller waits for a new request
    assign s_tready = cmd.accept;

endmodule

`default_nettype wire

FILE: bench/tb_fingerprint_duplicate_table.sv
// Self-checking bench for the fingerprint duplicate table: random streams against a table model.
`default_nettype none

module tb_fingerprint_duplicate_table;
    import fdt_pkg::*;

    // Quiet cycles allowed: a clear sweep, a long receiver
    // hold and a long sender gap, taken several times over
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_SPACING   = 2500;

    // One request: opcode in tuser, fingerprint words in tdata (head lowest)
    typedef struct packed
    {
        opcode_t     op;
        logic [63:0] tail;
        logic [63:0] mid;
        logic [31:0] head;
    } fpr_req_t;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    // Stimulus and scoreboard
    fpr_req_t     pending_reqs [$];
    logic [159:0] seen_fprs [$];
    status_t      awaited_status [$];
    int           faults = 0;

    // Table model: bucket heads, entry pool and fill count
    logic                  tbl_head_ok  [BUCKETS];
    logic [ENTRY_BITS-1:0] tbl_head_ptr [BUCKETS];
    logic [23:0]           pool_top     [POOL_ENTRIES];
    logic [63:0]           pool_mid     [POOL_ENTRIES];
    logic [63:0]           pool_low     [POOL_ENTRIES];
    logic                  pool_link_ok [POOL_ENTRIES];
    logic [ENTRY_BITS-1:0] pool_link    [POOL_ENTRIES];
    int                    pool_fill;

    fingerprint_duplicate_table u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the table model and return the status it earns.
    // A clear drops every bucket and empties the pool; stale keys stay but
    // can no longer be reached.
    function automatic status_t lookup_or_insert(input fpr_req_t req);
        logic [INDEX_BITS-1:0] bkt;
        logic                  ok;
        logic [ENTRY_BITS-1:0] at;
        int                    walked;
        int                    b;
        if (req.op == OP_CLEAR)
        begin
            for (b = 0; b < BUCKETS; b++)
            begin
                tbl_head_ok[b] = 1'b0;
            end
            pool_fill = 0;
            return STAT_CLEARED;
        end
        // Bucket: byte 0 above the low nibble of byte 1
        bkt    = {req.head[31:24], req.head[19:16]};
        ok     = tbl_head_ok[bkt];
        at     = tbl_head_ptr[bkt];
        walked = 0;
        // Compare bytes 1..19 down the chain, never further than the pool fill
        while (ok && walked < pool_fill)
        begin
            if (pool_top[at] == req.head[23:0] && pool_mid[at] == req.mid &&
                pool_low[at] == req.tail)
            begin
                return STAT_PRESENT;
            end
            ok = pool_link_ok[at];
            at = pool_link[at];
            walked++;
        end
        if (pool_fill >= POOL_ENTRIES)
        begin
            return STAT_FULL;
        end
        // Link the new entry in front of the old head
        at                = pool_fill[ENTRY_BITS-1:0];
        pool_top[at]      = req.head[23:0];
        pool_mid[at]      = req.mid;
        pool_low[at]      = req.tail;
        pool_link_ok[at]  = tbl_head_ok[bkt];
        pool_link[at]     = tbl_head_ptr[bkt];
        tbl_head_ok[bkt]  = 1'b1;
        tbl_head_ptr[bkt] = at;
        pool_fill++;
        return STAT_INSERTED;
    endfunction

    // Mostly back-to-back, some short gaps, now and then a long one
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [159:0] fresh_fpr();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic add_insert(input logic [159:0] fp);
        fpr_req_t req;
        req.op                        = OP_INSERT;
        {req.tail, req.mid, req.head} = fp;
        pending_reqs.push_back(req);
        seen_fprs.push_back(fp);
    endtask

    // The fingerprint words of a clear carry random junk
    task automatic add_clear();
        fpr_req_t req;
        req.op                        = OP_CLEAR;
        {req.tail, req.mid, req.head} = fresh_fpr();
        pending_reqs.push_back(req);
    endtask

    // Random mix: repeats, one-bit near misses, crowded buckets, fresh keys
    // and the odd clear
    task automatic add_mixed(input int count);
        int            r;
        logic [159:0]  fp;
        logic [11:0]   hb;
        logic [31:0]   rn;
        repeat (count)
        begin
            r = $urandom_range(0, 999);
            if (r < 8)
            begin
                add_clear();
            end
            else if (r < 300)
            begin
                add_insert(seen_fprs[$urandom_range(0, seen_fprs.size() - 1)]);
            end
            else if (r < 450)
            begin
                fp = seen_fprs[$urandom_range(0, seen_fprs.size() - 1)];
                add_insert(fp ^ (160'd1 << $urandom_range(0, 159)));
            end
            else if (r < 750)
            begin
                // Pile keys into a handful of buckets to grow long chains
                case ($urandom_range(0, 3))
                    0:       hb = 12'h000;
                    1:       hb = 12'hFFF;
                    2:       hb = 12'h5A3;
                    default: hb = 12'h801;
                endcase
                rn = $urandom;
                fp = fresh_fpr();
                fp[31:0] = {hb[11:4], rn[3:0], hb[3:0], rn[31:16]};
                add_insert(fp);
            end
            else
            begin
                add_insert(fresh_fpr());
            end
        end
    endtask

    task automatic add_directed();
        logic [159:0] zero_fp;
        logic [159:0] last_byte_fp;
        zero_fp      = '0;
        last_byte_fp = 160'd1 << 96;                  // byte 19 bit 0 only
        add_clear();                                  // clear of an empty table
        add_insert(zero_fp);
        add_insert(zero_fp);                          // repeat at chain head
        add_insert('1);
        add_insert('1);
        add_insert(last_byte_fp);                     // same bucket, last byte differs
        add_insert(zero_fp);                          // hit one step down the chain
        add_insert(160'h00F0_0000);                   // byte 1 high nibble: same bucket
        add_insert(160'h0100_0000);                   // byte 0 only: other bucket
        add_insert(160'h0001_0000);                   // byte 1 low nibble: other bucket
        add_insert(160'h0000_0080);                   // byte 3 top bit
        add_insert(160'd1 << 95);                     // byte 4 top bit
        add_insert(160'd1 << 159);                    // byte 12 top bit
        add_insert(last_byte_fp);                     // deep hit
        add_insert(160'h00F0_0000);
        add_clear();
        add_insert(zero_fp);                          // stale chain must be ignored
        add_insert('1);
        add_insert(last_byte_fp);
        add_insert(zero_fp);
        add_clear();
    endtask

    // Driver: advance to the next request once the current one is taken.
    // Predict at the acceptance edge so model order matches block order.
    int       tx_gap;
    bit       tx_steady;
    fpr_req_t cur_req;
    int       rx_hold;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            tx_gap    <= 0;
            tx_steady <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_status.push_back(lookup_or_insert(cur_req));
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req  = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req[159:0];
                    s_tuser  <= cur_req.op;
                    // Keep offering while the receiver holds off
                    tx_gap   <= (rx_hold != 0) ? 0 : pick_gap(tx_steady);
                    if ($urandom_range(0, 63) == 0)
                    begin
                        tx_steady <= !tx_steady;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take results with random stalls, and now and then hold off
    // long enough for the block to back up onto its input
    int      rx_gap;
    bit      rx_steady;
    int      results_seen;
    int      next_hold_at;
    status_t want_status;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_gap       <= 0;
            rx_hold      <= 0;
            rx_steady    <= 1'b0;
            results_seen = 0;
            next_hold_at = 40;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (awaited_status.size() == 0)
                begin
                    $display("%0t: status %0d with no request outstanding",
                             $time, m_tdata[1:0]);
                    faults++;
                end
                else
                begin
                    want_status = awaited_status.pop_front();
                    if (m_tdata[1:0] !== want_status)
                    begin
                        $display("%0t: status mismatch: expected %s (%0d), actual %0d",
                                 $time, want_status.name(), want_status, m_tdata[1:0]);
                        faults++;
                    end
                end
            end
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold  <= rx_hold - 1;
            end
            else if (results_seen >= next_hold_at)
            begin
                m_tready     <= 1'b0;
                rx_hold      <= HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap   <= pick_gap(rx_steady);
                if ($urandom_range(0, 63) == 0)
                begin
                    rx_steady <= !rx_steady;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves anything
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("tb_fingerprint_duplicate_table: errors");
                $finish;
            end
        end
    end

    initial
    begin
        for (int b = 0; b < BUCKETS; b++)
        begin
            tbl_head_ok[b] = 1'b0;
        end
        pool_fill = 0;

        add_directed();
        add_mixed(700);
        add_mixed(730);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every request is taken and every status has come back
        @(negedge clk);
        while (pending_reqs.size() > 0 || s_tvalid || awaited_status.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
        begin
            $display("tb_fingerprint_duplicate_table: clean");
        end
        else
        begin
            $display("tb_fingerprint_duplicate_table: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
